[rtl/core/pctp_pkg.sv]
`default_nettype none
package pctp_pkg;

    localparam int MAX_INTERVALS = 16;
    localparam int IDX_W         = $clog2(MAX_INTERVALS);
    localparam int CNT_W         = 5;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 16;
    localparam int TOL_W         = 16;

    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_SUM_TOL    = 4'd1;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_B_BEFORE_A   = 2'd1;
    localparam logic [1:0] STATUS_NO_OVERLAP   = 2'd2;
    localparam logic [1:0] STATUS_BAD_GENERATOR = 2'd3;

    localparam logic [4:0]  SERIES_TERMS = 5'd20;
    localparam logic [31:0] EXP_M1_Q32   = 32'd1580030169;

    typedef struct packed {
        logic               action;
        logic [3:0]         entry_index;
        logic signed [31:0] interval_start;
        logic signed [31:0] interval_end;
        logic signed [31:0] rate_00;
        logic signed [31:0] rate_01;
        logic signed [31:0] rate_10;
        logic signed [31:0] rate_11;
        logic signed [31:0] query_a;
        logic signed [31:0] query_b;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] prob_00;
        logic signed [31:0] prob_01;
        logic signed [31:0] prob_10;
        logic signed [31:0] prob_11;
    } out_beat_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_FETCH,
        OP_EVAL,
        OP_NEXT,
        OP_MUL_LK,
        OP_EXP_BIG,
        OP_SERIES_INIT,
        OP_MUL_TF,
        OP_DIV_T,
        OP_SERIES_ACC,
        OP_SERIES_END,
        OP_MUL_EE,
        OP_EXP_STEP,
        OP_OME,
        OP_MUL_FAC,
        OP_DIV_F,
        OP_FAC_STORE,
        OP_DOT_A,
        OP_DOT_B,
        OP_DOT_END,
        OP_COMMIT,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] code;
        logic       zero_prob;
    } cmd_t;

    typedef struct packed {
        logic b_lt_a;
        logic a_eq_b;
        logic walk_done;
        logic hit;
        logic ovl;
        logic inv;
        logic lam_zero;
        logic big;
        logic div_done;
        logic series_last;
        logic ip_zero;
        logic fac_last;
        logic dot_last;
    } stat_t;

endpackage
`default_nettype wire

[rtl/core/piecewise_ctmc_transition_product.sv]
// Channel   Direction  Signals                                  Beat
// s_        in         s_valid, s_ready, s_payload (in_beat_t)  load entry or query
// m_        out        m_valid, m_ready, m_payload (out_beat_t) status and 2x2 product
// cfg_      in         cfg_valid, cfg_ready, cfg_index, cfg_data register write
//
// A query walks the table one entry after another. For an overlapping entry with a
// nonzero exit rate and a small exponent, the walk runs the 20-term series, where each
// term waits on the bit-serial divider.
// Synchronous active-low reset returns the controller to idle; table contents stay.
// A stalled result is held in the output register; a new beat is taken only when idle.
`default_nettype none
module piecewise_ctmc_transition_product (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire pctp_pkg::in_beat_t               s_payload,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output pctp_pkg::out_beat_t                   m_payload,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [pctp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pctp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pctp_pkg::cmd_t  cmd;
    pctp_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    pctp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_payload.action),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pctp_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_payload (m_payload)
    );

endmodule
`default_nettype wire

[rtl/core/pctp_divider.sv]
`default_nettype none
module pctp_divider (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [33:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [33:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [33:0] dvs_reg, dvs_next;
    logic [34:0] trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[63]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd63;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // One quotient bit per cycle, restoring form.
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = 34'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = trial[33:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

[rtl/core/pctp_datapath.sv]
`default_nettype none
module pctp_datapath (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire pctp_pkg::in_beat_t                   s_payload,
    input  wire logic                                 cfg_valid,
    input  wire logic [pctp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [pctp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire pctp_pkg::cmd_t                       cmd,
    output pctp_pkg::stat_t                           stat,
    output pctp_pkg::out_beat_t                       m_payload
);

    // Interval table: start in the low half, end in the high half.
    logic [63:0]  bounds_mem [pctp_pkg::MAX_INTERVALS];
    // Generator table: one row pair per entry, q00 in the lowest word.
    logic [127:0] gen_mem    [pctp_pkg::MAX_INTERVALS];

    logic [pctp_pkg::CNT_W-1:0] count_cfg_reg;
    logic [pctp_pkg::TOL_W-1:0] tol_reg;

    logic signed [31:0] a_reg, b_reg;
    logic signed [31:0] s_reg, e_reg_t;
    logic signed [31:0] q_reg [4];
    logic [pctp_pkg::CNT_W-1:0] j_reg;
    logic        hit_reg;
    logic        ovl_reg, inv_reg, lz_reg;
    logic [31:0] k_reg, lambda_reg;
    logic signed [67:0] prod_reg, acc_reg;
    logic [32:0] t_reg;
    logic [31:0] f_reg;
    logic [4:0]  ip_reg;
    logic [4:0]  i_reg;
    logic signed [35:0] sum_reg;
    logic [32:0] ex_reg;
    logic [32:0] ome_reg;
    logic [1:0]  fidx_reg, nidx_reg;
    logic signed [31:0] fac_reg [4];
    logic signed [31:0] p_reg [4];
    logic signed [31:0] n_reg [4];
    pctp_pkg::out_beat_t res_reg;

    logic [pctp_pkg::CNT_W-1:0] count_eff;
    logic signed [31:0] left, right;
    logic signed [32:0] diff, r0, r1, neg_tol;
    logic [32:0] r0_mag, r1_mag;
    logic        ovl_c, inv_c;
    logic [31:0] lambda_c;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic signed [31:0] q_sel;
    logic [31:0] m_sel;
    logic        div_start;
    logic [63:0] div_dividend;
    logic [33:0] div_divisor;
    logic        div_done;
    logic [63:0] div_quo;
    logic [63:0] mag_raw;
    logic [34:0] mag_c;
    logic signed [35:0] fv;
    logic signed [35:0] fv_d;
    logic signed [31:0] fac_c;
    logic signed [68:0] dsum, dsh;
    logic signed [31:0] dot_c;
    logic [64:0] es;
    logic [1:0]  row_idx;
    logic        col_idx;

    assign count_eff = (count_cfg_reg > pctp_pkg::CNT_W'(pctp_pkg::MAX_INTERVALS)) ?
                       pctp_pkg::CNT_W'(pctp_pkg::MAX_INTERVALS) : count_cfg_reg;

    // Overlap and generator checks for the fetched entry.
    always_comb begin
        left     = (a_reg > s_reg) ? a_reg : s_reg;
        right    = (b_reg < e_reg_t) ? b_reg : e_reg_t;
        diff     = 33'({right[31], right} - {left[31], left});
        ovl_c    = (s_reg < b_reg) && (e_reg_t > a_reg) && (diff > 33'sd0);
        r0       = 33'({q_reg[0][31], q_reg[0]} + {q_reg[1][31], q_reg[1]});
        r1       = 33'({q_reg[2][31], q_reg[2]} + {q_reg[3][31], q_reg[3]});
        r0_mag   = r0[32] ? 33'(-r0) : r0;
        r1_mag   = r1[32] ? 33'(-r1) : r1;
        neg_tol  = 33'sd0 - $signed({17'd0, tol_reg});
        inv_c    = (r0_mag > {17'd0, tol_reg}) || (r1_mag > {17'd0, tol_reg}) ||
                   ($signed({q_reg[1][31], q_reg[1]}) < neg_tol) ||
                   ($signed({q_reg[2][31], q_reg[2]}) < neg_tol);
        lambda_c = (q_reg[1][31] ? 32'd0 : q_reg[1]) + (q_reg[2][31] ? 32'd0 : q_reg[2]);
    end

    assign q_sel   = q_reg[fidx_reg];
    assign m_sel   = q_sel[31] ? 32'(-q_sel) : q_sel;
    assign row_idx = {nidx_reg[1], 1'b0};
    assign col_idx = nidx_reg[0];

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            pctp_pkg::OP_MUL_LK: begin
                mul_a = $signed({2'b00, lambda_reg});
                mul_b = $signed({2'b00, k_reg});
            end
            pctp_pkg::OP_MUL_TF: begin
                mul_a = $signed({1'b0, t_reg});
                mul_b = $signed({2'b00, f_reg});
            end
            pctp_pkg::OP_MUL_EE: begin
                mul_a = $signed({1'b0, ex_reg});
                mul_b = $signed({2'b00, pctp_pkg::EXP_M1_Q32});
            end
            pctp_pkg::OP_MUL_FAC: begin
                mul_a = lz_reg ? $signed({2'b00, k_reg}) : $signed({1'b0, ome_reg});
                mul_b = $signed({2'b00, m_sel});
            end
            pctp_pkg::OP_DOT_A: begin
                mul_a = 34'(p_reg[row_idx]);
                mul_b = 34'(fac_reg[{1'b0, col_idx}]);
            end
            pctp_pkg::OP_DOT_B: begin
                mul_a = 34'(p_reg[row_idx | 2'd1]);
                mul_b = 34'(fac_reg[{1'b1, col_idx}]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign div_start    = (cmd.op == pctp_pkg::OP_DIV_T) || (cmd.op == pctp_pkg::OP_DIV_F);
    assign div_dividend = (cmd.op == pctp_pkg::OP_DIV_T) ? {32'd0, prod_reg[63:32]} :
                                                           prod_reg[63:0];
    assign div_divisor  = (cmd.op == pctp_pkg::OP_DIV_T) ? {29'd0, i_reg} :
                                                           {lambda_reg, 2'b00};

    pctp_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Factor entry: clamp the magnitude, restore the sign, add one on the diagonal.
    always_comb begin
        mag_raw = lz_reg ? {10'd0, prod_reg[63:10]} : div_quo;
        mag_c   = (mag_raw > 64'h4_0000_0000) ? 35'h4_0000_0000 : mag_raw[34:0];
        fv      = q_sel[31] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
        fv_d    = ((fidx_reg == 2'd0) || (fidx_reg == 2'd3)) ?
                  36'(fv + 36'sd1073741824) : fv;
        if (fv_d > 36'sd2147483647)       fac_c = 32'sh7FFFFFFF;
        else if (fv_d < -36'sd2147483648) fac_c = 32'sh80000000;
        else                              fac_c = fv_d[31:0];
    end

    // Product entry rounded to nearest, ties up.
    always_comb begin
        dsum = 69'($signed({acc_reg[67], acc_reg}) + $signed({prod_reg[67], prod_reg})
                   + 69'sd536870912);
        dsh  = dsum >>> 30;
        if (dsh > 69'sd2147483647)       dot_c = 32'sh7FFFFFFF;
        else if (dsh < -69'sd2147483648) dot_c = 32'sh80000000;
        else                             dot_c = dsh[31:0];
    end

    assign es = 65'(prod_reg[64:0] + 65'h8000_0000);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_cfg_reg <= pctp_pkg::CNT_W'(1);
            tol_reg       <= '0;
            hit_reg       <= 1'b0;
            j_reg         <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == pctp_pkg::REG_INTERVAL_COUNT) begin
                    count_cfg_reg <= cfg_data[pctp_pkg::CNT_W-1:0];
                end else if (cfg_index == pctp_pkg::REG_ROW_SUM_TOL) begin
                    tol_reg <= cfg_data[pctp_pkg::TOL_W-1:0];
                end
            end
            case (cmd.op)
                pctp_pkg::OP_START: begin
                    hit_reg <= 1'b0;
                    j_reg   <= '0;
                end
                pctp_pkg::OP_NEXT: j_reg <= j_reg + pctp_pkg::CNT_W'(1);
                pctp_pkg::OP_COMMIT: begin
                    hit_reg <= 1'b1;
                    j_reg   <= j_reg + pctp_pkg::CNT_W'(1);
                end
                default: ;
            endcase
        end

        case (cmd.op)
            pctp_pkg::OP_LOAD: begin
                bounds_mem[s_payload.entry_index] <=
                    {s_payload.interval_end, s_payload.interval_start};
                gen_mem[s_payload.entry_index] <=
                    {s_payload.rate_11, s_payload.rate_10, s_payload.rate_01, s_payload.rate_00};
            end
            pctp_pkg::OP_START: begin
                a_reg    <= s_payload.query_a;
                b_reg    <= s_payload.query_b;
                p_reg[0] <= 32'sh40000000;
                p_reg[1] <= '0;
                p_reg[2] <= '0;
                p_reg[3] <= 32'sh40000000;
            end
            pctp_pkg::OP_FETCH: begin
                s_reg    <= bounds_mem[j_reg[pctp_pkg::IDX_W-1:0]][31:0];
                e_reg_t  <= bounds_mem[j_reg[pctp_pkg::IDX_W-1:0]][63:32];
                q_reg[0] <= gen_mem[j_reg[pctp_pkg::IDX_W-1:0]][31:0];
                q_reg[1] <= gen_mem[j_reg[pctp_pkg::IDX_W-1:0]][63:32];
                q_reg[2] <= gen_mem[j_reg[pctp_pkg::IDX_W-1:0]][95:64];
                q_reg[3] <= gen_mem[j_reg[pctp_pkg::IDX_W-1:0]][127:96];
            end
            pctp_pkg::OP_EVAL: begin
                ovl_reg    <= ovl_c;
                inv_reg    <= inv_c;
                k_reg      <= diff[31:0];
                lambda_reg <= lambda_c;
                lz_reg     <= (lambda_c == 32'd0);
                fidx_reg   <= '0;
                nidx_reg   <= '0;
            end
            pctp_pkg::OP_MUL_LK, pctp_pkg::OP_MUL_TF, pctp_pkg::OP_MUL_EE,
            pctp_pkg::OP_MUL_FAC, pctp_pkg::OP_DOT_A: begin
                prod_reg <= mul_p;
            end
            pctp_pkg::OP_DOT_B: begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            pctp_pkg::OP_EXP_BIG: ome_reg <= 33'h1_0000_0000;
            pctp_pkg::OP_SERIES_INIT: begin
                // The exponent lambda*k is in units of 2^-40; keep Q5.32.
                ip_reg  <= prod_reg[44:40];
                f_reg   <= prod_reg[39:8];
                t_reg   <= 33'h1_0000_0000;
                sum_reg <= 36'sh1_0000_0000;
                i_reg   <= 5'd1;
            end
            pctp_pkg::OP_SERIES_ACC: begin
                t_reg   <= div_quo[32:0];
                sum_reg <= i_reg[0] ? 36'(sum_reg - $signed({3'b000, div_quo[32:0]})) :
                                      36'(sum_reg + $signed({3'b000, div_quo[32:0]}));
                i_reg   <= i_reg + 5'd1;
            end
            pctp_pkg::OP_SERIES_END: ex_reg <= sum_reg[35] ? 33'd0 : sum_reg[32:0];
            pctp_pkg::OP_EXP_STEP: begin
                ex_reg <= es[64:32];
                ip_reg <= ip_reg - 5'd1;
            end
            pctp_pkg::OP_OME: ome_reg <= 33'(33'h1_0000_0000 - ex_reg);
            pctp_pkg::OP_FAC_STORE: begin
                fac_reg[fidx_reg] <= fac_c;
                fidx_reg          <= fidx_reg + 2'd1;
            end
            pctp_pkg::OP_DOT_END: begin
                n_reg[nidx_reg] <= dot_c;
                nidx_reg        <= nidx_reg + 2'd1;
            end
            pctp_pkg::OP_COMMIT: begin
                p_reg[0] <= n_reg[0];
                p_reg[1] <= n_reg[1];
                p_reg[2] <= n_reg[2];
                p_reg[3] <= n_reg[3];
            end
            pctp_pkg::OP_RESULT: begin
                res_reg.status  <= cmd.code;
                res_reg.prob_00 <= cmd.zero_prob ? 32'sd0 : p_reg[0];
                res_reg.prob_01 <= cmd.zero_prob ? 32'sd0 : p_reg[1];
                res_reg.prob_10 <= cmd.zero_prob ? 32'sd0 : p_reg[2];
                res_reg.prob_11 <= cmd.zero_prob ? 32'sd0 : p_reg[3];
            end
            default: ;
        endcase
    end

    always_comb begin
        stat.b_lt_a      = b_reg < a_reg;
        stat.a_eq_b      = b_reg == a_reg;
        stat.walk_done   = j_reg >= count_eff;
        stat.hit         = hit_reg;
        stat.ovl         = ovl_reg;
        stat.inv         = inv_reg;
        stat.lam_zero    = lz_reg;
        stat.big         = prod_reg[67:45] != 23'd0;
        stat.div_done    = div_done;
        stat.series_last = i_reg == pctp_pkg::SERIES_TERMS;
        stat.ip_zero     = ip_reg == 5'd0;
        stat.fac_last    = fidx_reg == 2'd3;
        stat.dot_last    = nidx_reg == 2'd3;
    end

    assign m_payload = res_reg;

endmodule
`default_nettype wire

[rtl/core/pctp_ctrl.sv]
`default_nettype none
module pctp_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_action,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire pctp_pkg::stat_t  stat,
    output pctp_pkg::cmd_t        cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        W_TEST,
        W_EVAL,
        W_DEC,
        X_INIT,
        S_MUL,
        S_DIV,
        S_WAIT,
        S_END,
        E_TEST,
        E_STEP,
        F_MUL,
        F_DIV,
        F_WAIT,
        M_A,
        M_B,
        M_END,
        M_COMMIT,
        S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic [1:0] code_reg, code_next;
    logic       zero_reg, zero_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        code_next    = code_reg;
        zero_next    = zero_reg;
        cmd.op       = pctp_pkg::OP_NONE;
        cmd.code     = code_reg;
        cmd.zero_prob = zero_reg;
        s_ready      = (state_reg == S_IDLE);
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_action == pctp_pkg::ACT_LOAD) begin
                        cmd.op     = pctp_pkg::OP_LOAD;
                        code_next  = pctp_pkg::STATUS_OK;
                        zero_next  = 1'b1;
                        state_next = S_OUT;
                    end else begin
                        cmd.op     = pctp_pkg::OP_START;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (stat.b_lt_a) begin
                    code_next  = pctp_pkg::STATUS_B_BEFORE_A;
                    zero_next  = 1'b1;
                    state_next = S_OUT;
                end else if (stat.a_eq_b) begin
                    code_next  = pctp_pkg::STATUS_OK;
                    zero_next  = 1'b0;
                    state_next = S_OUT;
                end else begin
                    state_next = W_TEST;
                end
            end
            W_TEST: begin
                if (stat.walk_done) begin
                    code_next  = stat.hit ? pctp_pkg::STATUS_OK : pctp_pkg::STATUS_NO_OVERLAP;
                    zero_next  = !stat.hit;
                    state_next = S_OUT;
                end else begin
                    cmd.op     = pctp_pkg::OP_FETCH;
                    state_next = W_EVAL;
                end
            end
            W_EVAL: begin
                cmd.op     = pctp_pkg::OP_EVAL;
                state_next = W_DEC;
            end
            W_DEC: begin
                if (!stat.ovl) begin
                    cmd.op     = pctp_pkg::OP_NEXT;
                    state_next = W_TEST;
                end else if (stat.inv) begin
                    code_next  = pctp_pkg::STATUS_BAD_GENERATOR;
                    zero_next  = 1'b1;
                    state_next = S_OUT;
                end else if (stat.lam_zero) begin
                    state_next = F_MUL;
                end else begin
                    cmd.op     = pctp_pkg::OP_MUL_LK;
                    state_next = X_INIT;
                end
            end
            X_INIT: begin
                // A large exponent makes the decay term vanish.
                if (stat.big) begin
                    cmd.op     = pctp_pkg::OP_EXP_BIG;
                    state_next = F_MUL;
                end else begin
                    cmd.op     = pctp_pkg::OP_SERIES_INIT;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.op     = pctp_pkg::OP_MUL_TF;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op     = pctp_pkg::OP_DIV_T;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (stat.div_done) begin
                    cmd.op     = pctp_pkg::OP_SERIES_ACC;
                    state_next = stat.series_last ? S_END : S_MUL;
                end
            end
            S_END: begin
                cmd.op     = pctp_pkg::OP_SERIES_END;
                state_next = E_TEST;
            end
            E_TEST: begin
                if (stat.ip_zero) begin
                    cmd.op     = pctp_pkg::OP_OME;
                    state_next = F_MUL;
                end else begin
                    cmd.op     = pctp_pkg::OP_MUL_EE;
                    state_next = E_STEP;
                end
            end
            E_STEP: begin
                cmd.op     = pctp_pkg::OP_EXP_STEP;
                state_next = E_TEST;
            end
            F_MUL: begin
                cmd.op     = pctp_pkg::OP_MUL_FAC;
                state_next = F_DIV;
            end
            F_DIV: begin
                if (stat.lam_zero) begin
                    cmd.op     = pctp_pkg::OP_FAC_STORE;
                    state_next = stat.fac_last ? M_A : F_MUL;
                end else begin
                    cmd.op     = pctp_pkg::OP_DIV_F;
                    state_next = F_WAIT;
                end
            end
            F_WAIT: begin
                if (stat.div_done) begin
                    cmd.op     = pctp_pkg::OP_FAC_STORE;
                    state_next = stat.fac_last ? M_A : F_MUL;
                end
            end
            M_A: begin
                cmd.op     = pctp_pkg::OP_DOT_A;
                state_next = M_B;
            end
            M_B: begin
                cmd.op     = pctp_pkg::OP_DOT_B;
                state_next = M_END;
            end
            M_END: begin
                cmd.op     = pctp_pkg::OP_DOT_END;
                state_next = stat.dot_last ? M_COMMIT : M_A;
            end
            M_COMMIT: begin
                cmd.op     = pctp_pkg::OP_COMMIT;
                state_next = W_TEST;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = pctp_pkg::OP_RESULT;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            code_reg    <= pctp_pkg::STATUS_OK;
            zero_reg    <= 1'b1;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            code_reg    <= code_next;
            zero_reg    <= zero_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

[dv/piecewise_ctmc_transition_product_tb.sv]
`default_nettype none
module piecewise_ctmc_transition_product_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pctp_pkg::*;

    localparam longint ONE_Q30    = 64'sd1073741824;
    localparam longint TIME_LIMIT = 20_000_000;

    class prob_scoreboard;
        logic [31:0] ent_start [MAX_INTERVALS];
        logic [31:0] ent_end [MAX_INTERVALS];
        logic [31:0] ent_rate [MAX_INTERVALS][4];
        int unsigned walk_count = 1;
        int unsigned tolerance  = 0;
        out_beat_t   pending_probs [$];
        int          errors = 0;

        function longint sx(logic [31:0] v);
            return longint'(signed'(v));
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint floor_q30(longint p, output longint rem);
            longint q;
            if (p >= 0) q = p / ONE_Q30;
            else q = -((-p + ONE_Q30 - 1) / ONE_Q30);
            rem = p - q * ONE_Q30;
            return q;
        endfunction

        function longint dot_q30(longint a, longint b, longint c, longint d);
            longint r1, r2, q1, q2;
            q1 = floor_q30(a * b, r1);
            q2 = floor_q30(c * d, r2);
            return sat32(q1 + q2 + ((r1 + r2 + ONE_Q30 / 2) / ONE_Q30));
        endfunction

        // exp(-lambda*k) in Q1.32.
        function longint unsigned decay_q32(longint unsigned lam, longint unsigned k);
            longint unsigned lim, x, ip, f, t, e;
            longint sum;
            lim = (64'd1 << 45) - 64'd1;
            if (lam > lim / k) return 0;
            x  = (lam * k) >> 8;
            ip = x >> 32;
            f  = x & 64'hFFFF_FFFF;
            t  = 64'd1 << 32;
            sum = longint'(t);
            for (int i = 1; i <= 20; i++) begin
                t = ((t * f) >> 32) / longint'(i);
                if (i % 2 == 1) sum -= longint'(t);
                else sum += longint'(t);
            end
            if (sum < 0) sum = 0;
            e = longint'(sum);
            for (longint unsigned i = 0; i < ip; i++)
                e = (e * 64'd1580030169 + (64'd1 << 31)) >> 32;
            return e;
        endfunction

        function longint step_entry(longint q, longint unsigned lam, longint unsigned k,
                                    longint unsigned ome, bit diag);
            longint unsigned m, mag;
            longint v;
            m = (q < 0) ? longint'(-q) : longint'(q);
            if (lam == 0) mag = (k * m) >> 10;
            else mag = (ome * m) / (lam << 2);
            if (mag > (64'd1 << 34)) mag = 64'd1 << 34;
            v = (q < 0) ? -longint'(mag) : longint'(mag);
            if (diag) v += ONE_Q30;
            return sat32(v);
        endfunction

        function out_beat_t predict_query(in_beat_t it);
            out_beat_t r;
            longint p[4], n[4], f[4], q[4];
            longint a, b, s, e, left, right, r0, r1, tol;
            longint unsigned k, lam, ome;
            int unsigned cnt;
            bit hit;
            logic [1:0] st;
            p[0] = ONE_Q30; p[1] = 0; p[2] = 0; p[3] = ONE_Q30;
            a = sx(it.query_a);
            b = sx(it.query_b);
            cnt = (walk_count > MAX_INTERVALS) ? MAX_INTERVALS : walk_count;
            tol = longint'(tolerance);
            st = STATUS_OK;
            hit = 0;
            if (b < a) begin
                st = STATUS_B_BEFORE_A;
            end else if (b != a) begin
                for (int j = 0; j < cnt; j++) begin
                    s = sx(ent_start[j]);
                    e = sx(ent_end[j]);
                    left  = (a > s) ? a : s;
                    right = (b < e) ? b : e;
                    if (!(s < b && e > a) || right - left <= 0) continue;
                    k = longint'(right - left);
                    for (int c = 0; c < 4; c++) q[c] = sx(ent_rate[j][c]);
                    r0 = q[0] + q[1];
                    r1 = q[2] + q[3];
                    if ((r0 < 0 ? -r0 : r0) > tol || (r1 < 0 ? -r1 : r1) > tol ||
                        q[1] < -tol || q[2] < -tol) begin
                        st = STATUS_BAD_GENERATOR;
                        break;
                    end
                    lam = longint'((q[1] > 0 ? q[1] : 0) + (q[2] > 0 ? q[2] : 0));
                    ome = 0;
                    if (lam != 0) ome = (64'd1 << 32) - decay_q32(lam, k);
                    f[0] = step_entry(q[0], lam, k, ome, 1'b1);
                    f[1] = step_entry(q[1], lam, k, ome, 1'b0);
                    f[2] = step_entry(q[2], lam, k, ome, 1'b0);
                    f[3] = step_entry(q[3], lam, k, ome, 1'b1);
                    n[0] = dot_q30(p[0], f[0], p[1], f[2]);
                    n[1] = dot_q30(p[0], f[1], p[1], f[3]);
                    n[2] = dot_q30(p[2], f[0], p[3], f[2]);
                    n[3] = dot_q30(p[2], f[1], p[3], f[3]);
                    p = n;
                    hit = 1;
                end
                if (st == STATUS_OK && !hit) st = STATUS_NO_OVERLAP;
            end
            r = '0;
            r.status = st;
            if (st == STATUS_OK) begin
                r.prob_00 = p[0][31:0];
                r.prob_01 = p[1][31:0];
                r.prob_10 = p[2][31:0];
                r.prob_11 = p[3][31:0];
            end
            return r;
        endfunction

        function void note_input(in_beat_t it);
            if (it.action == ACT_LOAD) begin
                ent_start[it.entry_index] = it.interval_start;
                ent_end[it.entry_index]   = it.interval_end;
                ent_rate[it.entry_index][0] = it.rate_00;
                ent_rate[it.entry_index][1] = it.rate_01;
                ent_rate[it.entry_index][2] = it.rate_10;
                ent_rate[it.entry_index][3] = it.rate_11;
                pending_probs.push_back('0);
            end else begin
                pending_probs.push_back(predict_query(it));
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t want;
            if (pending_probs.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
                errors++;
                return;
            end
            want = pending_probs.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("prob_00", want.prob_00, got.prob_00);
            compare_field("prob_01", want.prob_01, got.prob_01);
            compare_field("prob_10", want.prob_10, got.prob_10);
            compare_field("prob_11", want.prob_11, got.prob_11);
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_beat_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_beat_t m_payload;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    prob_scoreboard sb = new();
    longint cycles = 0;
    int gap_max = 8;

    piecewise_ctmc_transition_product uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > TIME_LIMIT) begin
            $display("piecewise_ctmc_transition_product_tb: FAIL");
            $finish;
        end
    end

    // Receiver: the stall pattern rotates through four modes: always ready, random, a square wave and mostly ready.
    always @(posedge aclk) begin
        if (m_valid && m_ready) sb.check_result(m_payload);
        case ((cycles >> 9) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(1);
            2: m_ready <= ((cycles >> 4) % 2 == 1);
            default: m_ready <= ($urandom_range(7) != 0);
        endcase
    end

    function automatic int rnd(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    task automatic send_beat(in_beat_t it);
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
    endtask

    task automatic idle_cycles(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_INTERVAL_COUNT) sb.walk_count = data & 16'h1F;
        else if (idx == REG_ROW_SUM_TOL) sb.tolerance = data;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_probs.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    function automatic in_beat_t load_beat(int idx, int st, int en, int q00, int q01,
                                           int q10, int q11);
        in_beat_t it;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom};
        it.action = ACT_LOAD;
        it.entry_index = idx;
        it.interval_start = st;
        it.interval_end = en;
        it.rate_00 = q00;
        it.rate_01 = q01;
        it.rate_10 = q10;
        it.rate_11 = q11;
        return it;
    endfunction

    function automatic in_beat_t query_beat(int a, int b);
        in_beat_t it;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom};
        it.action = ACT_QUERY;
        it.query_a = a;
        it.query_b = b;
        return it;
    endfunction

    // Generator that passes the row-sum and sign checks at tolerance tol, or fails the row-sum check when bad is set.
    function automatic in_beat_t entry_beat(int idx, int tol, bit bad);
        int st, en, q01, q10, q00, q11, w;
        st = (idx << 20) + rnd(0, 1 << 15);
        en = ((idx + 1) << 20) - rnd(0, 1 << 15);
        if ($urandom_range(15) == 0) begin
            w = st; st = en; en = w;
        end
        q01 = rnd(0, 1 << 28);
        q10 = rnd(0, 1 << 28);
        case ($urandom_range(7))
            0: q01 = 0;
            1: q10 = -rnd(0, tol);
            2: begin q01 = 0; q10 = 0; end
            default: ;
        endcase
        q00 = -q01 + rnd(-tol, tol);
        q11 = -q10 + rnd(-tol, tol);
        if (bad) q00 = q00 + tol + 1 + rnd(0, 1000);
        return load_beat(idx, st, en, q00, q01, q10, q11);
    endfunction

    initial begin
        int cnt_list[10] = '{1, 2, 4, 3, 0, 31, 16, 1, 5, 2};
        int tol_list[10] = '{65535, 0, 1000, 300, 65535, 7, 40000, 0, 65535, 12345};
        int burst, cnt_eff, j, a, b, r;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(REG_INTERVAL_COUNT, 16'hFFF0);
        write_reg(REG_ROW_SUM_TOL, 16'h0000);
        for (int i = 0; i < MAX_INTERVALS; i++) send_beat(entry_beat(i, 0, 1'b0));
        // Extreme bounds on the outer entries, a rate-free entry, a fast-decay entry,
        // and an entry whose start is not below its end.
        send_beat(load_beat(0, 32'h8000_0000, 1 << 20, -(1 << 24), 1 << 24, 1 << 23,
                            -(1 << 23)));
        send_beat(load_beat(15, 32'h7FFF_0000, 32'h7FFF_FFFF, -(1 << 20), 1 << 20, 0, 0));
        send_beat(load_beat(3, 3 << 20, 4 << 20, 0, 0, 0, 0));
        send_beat(load_beat(5, 5 << 20, 6 << 20, 32'h8000_0000, 32'h7FFF_FFFF + 1,
                            -(1 << 30), 1 << 30));
        send_beat(load_beat(5, 5 << 20, 6 << 20, -(1 << 30), 1 << 30, -(1 << 29), 1 << 29));
        send_beat(load_beat(7, 8 << 20, 7 << 20, 0, 0, 0, 0));
        send_beat(query_beat(1 << 20, 1 << 20));
        send_beat(query_beat(2 << 20, (2 << 20) - 1));
        send_beat(query_beat(32'h7FFE_0000, 32'h7FFE_8000));
        send_beat(query_beat((1 << 20) + 100, (2 << 20) - 100));
        send_beat(query_beat(3 << 20, 4 << 20));
        send_beat(query_beat(5 << 20, 6 << 20));
        send_beat(query_beat((7 << 20) + 10, (8 << 20) - 10));
        send_beat(query_beat(32'h8000_0000, 32'h7FFF_FFFF));
        send_beat(entry_beat(2, 0, 1'b1));
        send_beat(query_beat(2 << 20, 3 << 20));
        send_beat(entry_beat(2, 0, 1'b0));
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_INTERVAL_COUNT, {$urandom_range(2047), cnt_list[ph][4:0]});
            write_reg(REG_ROW_SUM_TOL, tol_list[ph]);
            gap_max = (ph % 3 == 2) ? 0 : 8;
            cnt_eff = (cnt_list[ph] > MAX_INTERVALS) ? MAX_INTERVALS : cnt_list[ph];
            if (cnt_eff == 0) cnt_eff = 4;
            burst = rnd(1, 20);
            for (int n = 0; n < 110; n++) begin
                r = $urandom_range(99);
                if (r < 42) begin
                    send_beat(entry_beat(rnd(0, MAX_INTERVALS - 1), tol_list[ph], 1'b0));
                end else if (r < 92) begin
                    j = rnd(0, cnt_eff - 1);
                    a = (j << 20) + rnd(-(1 << 18), 1 << 20);
                    case ($urandom_range(15))
                        0: b = a;
                        1: b = a - rnd(1, 1 << 16);
                        default: b = a + rnd(1, 3 << 19);
                    endcase
                    send_beat(query_beat(a, b));
                end else if (r < 95) begin
                    send_beat(entry_beat(rnd(0, MAX_INTERVALS - 1), tol_list[ph], 1'b1));
                end else if (r < 98) begin
                    send_beat(load_beat(rnd(0, MAX_INTERVALS - 1), $urandom, $urandom,
                                        $urandom, $urandom, $urandom, $urandom));
                end else begin
                    send_beat(query_beat($urandom, $urandom));
                end
                burst--;
                if (burst == 0) begin
                    burst = rnd(1, 20);
                    if (gap_max > 0) idle_cycles(rnd(1, gap_max));
                end
            end
            drain();
        end

        repeat (64) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_probs.size() == 0) begin
            $display("piecewise_ctmc_transition_product_tb: PASS");
        end else begin
            $display("piecewise_ctmc_transition_product_tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
